/* rtl/core/galvo_point_to_angles_assert.svh */
// Assertion macros for the galvo point-to-angles block.
// Needs clk and rst_n in the scope of the module that expands them.
`ifndef GALVO_POINT_TO_ANGLES_ASSERT_SVH
`define GALVO_POINT_TO_ANGLES_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpa assertion failed");
// next-cycle implication
`define GPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpa assertion failed");
`else
`define GPA_ASSERT_NOW(lbl, ante, cons)
`define GPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/gpa_pkg.sv */
// Shared constants, widths and helpers of the galvo point-to-angles block.
// No dependencies.
`default_nettype none
package gpa_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;

    // atan(2^-i) in 2^-16 degree
    localparam logic [21:0] ATAN_TAB [TAB_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    localparam int GAIN_Q30  = 652032874;
    localparam int Q30_FRAC  = 30;
    localparam int DEG180    = 46080;
    localparam int DEG90     = 23040;
    localparam int OUT_MAX   = 23040;
    localparam int VEC_SHIFT = 20;

    localparam int IN_W      = 24;
    localparam int ANG_W     = 17;
    localparam int GAP_W     = 16;
    localparam int OUT_W     = 16;
    localparam int COORD_W   = 27;
    localparam int COEF_W    = 32;
    localparam int SC_XY_W   = 34;
    localparam int Z_W       = 26;
    localparam int VEC_XY_W  = 52;
    localparam int SUM_W     = 56;
    localparam int ROOT_W    = 28;

    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [2:0] REG_ANGLE_X    = 3'd3;
    localparam logic [2:0] REG_ANGLE_Y    = 3'd4;
    localparam logic [2:0] REG_ANGLE_Z    = 3'd5;
    localparam logic [2:0] REG_MIRROR_GAP = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    // round half up to 1/256 degree, then clamp
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [Z_W-1:0] z);
        logic signed [Z_W-1:0] r;
        r = (z + Z_W'(128)) >>> 8;
        if (r > Z_W'(OUT_MAX))
            return OUT_W'(OUT_MAX);
        else if (r < -Z_W'(OUT_MAX))
            return -OUT_W'(OUT_MAX);
        else
            return OUT_W'(r);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/gpa_cordic_cell.sv */
// One CORDIC micro-rotation, registered; rotation or vectoring mode.
// Depends on gpa_pkg (arctangent table).
`default_nettype none
module gpa_cordic_cell #(
    parameter int XY_W   = 34,
    parameter int Z_W    = 26,
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(gpa_pkg::ATAN_TAB[STEP]);

    logic                   pos;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // pos: turn counterclockwise
    assign pos = VECTOR ? y_in[XY_W-1] : !z_in[Z_W-1];
    assign xs  = x_in >>> STEP;
    assign ys  = y_in >>> STEP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out <= pos ? x_in - ys : x_in + ys;
            y_out <= pos ? y_in + xs : y_in - xs;
            z_out <= pos ? z_in - ATAN : z_in + ATAN;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/gpa_sqrt_cell.sv */
// One bit of a pipelined floor square root, restoring form.
// Depends on nothing.
`default_nettype none
module gpa_sqrt_cell #(
    parameter int SUM_W  = 56,
    parameter int ROOT_W = 28,
    parameter int BIT    = 0
) (
    input  logic              clk,
    input  logic              en,
    input  logic [SUM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [SUM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    localparam int T_W = SUM_W + 2;

    logic [T_W-1:0] trial;
    logic [T_W-1:0] rem_ext;
    logic           fits;

    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    assign trial   = (T_W'(root_in) << (BIT + 1)) | (T_W'(1) << (2 * BIT));
    assign rem_ext = T_W'(rem_in);
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= fits ? SUM_W'(rem_ext - trial) : rem_in;
            root_out <= fits ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/gpa_mac.sv */
// Two-stage plane rotation: o1 = a*k1a + b*k1b, o2 = a*k2a + b*k2b, Q30 rounded.
// Depends on gpa_pkg.
`default_nettype none
module gpa_mac (
    input  logic            clk,
    input  logic            en,
    input  gpa_pkg::coord_t a,
    input  gpa_pkg::coord_t b,
    input  gpa_pkg::coef_t  k1a,
    input  gpa_pkg::coef_t  k1b,
    input  gpa_pkg::coef_t  k2a,
    input  gpa_pkg::coef_t  k2b,
    output gpa_pkg::coord_t o1,
    output gpa_pkg::coord_t o2
);

    localparam int P_W = gpa_pkg::COORD_W + gpa_pkg::COEF_W;
    localparam int S_W = P_W + 1;
    localparam logic signed [S_W-1:0] HALF = S_W'(1) <<< (gpa_pkg::Q30_FRAC - 1);

    logic signed [P_W-1:0] p1a_reg;
    logic signed [P_W-1:0] p1b_reg;
    logic signed [P_W-1:0] p2a_reg;
    logic signed [P_W-1:0] p2b_reg;
    logic signed [S_W-1:0] s1;
    logic signed [S_W-1:0] s2;

    assign s1 = S_W'(p1a_reg) + S_W'(p1b_reg) + HALF;
    assign s2 = S_W'(p2a_reg) + S_W'(p2b_reg) + HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1a_reg <= P_W'(a) * P_W'(k1a);
            p1b_reg <= P_W'(b) * P_W'(k1b);
            p2a_reg <= P_W'(a) * P_W'(k2a);
            p2b_reg <= P_W'(b) * P_W'(k2b);
            o1      <= gpa_pkg::COORD_W'(s1 >>> gpa_pkg::Q30_FRAC);
            o2      <= gpa_pkg::COORD_W'(s2 >>> gpa_pkg::Q30_FRAC);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/galvo_point_to_angles.sv */
// Top level of the galvo point-to-angles block: config registers, pipeline.
// Depends on gpa_pkg, gpa_cordic_cell, gpa_sqrt_cell, gpa_mac and the assert header.
//
// Usage:
//  - s_tdata beat: one camera-frame point (x, y, z, 24-bit signed, 1/256 mm).
//  - m_tdata beat: two optical angles (16-bit signed, 1/256 degree); m_tuser is
//    the valid flag. Points with z <= 0, and points whose rotated z is <= 0
//    (behind the galvo), give zero angles and m_tuser low.
//  - APB port: seven registers at 4*i (offsets, three angles, mirror gap).
//  - Throughput: one beat per cycle when neither stalled nor settling. From input
//    beat to m_tvalid the beat passes 9 fixed stages (offset, three two-stage
//    rotations, square, sum), 28 square-root cells, CORDIC_STEPS vectoring
//    cells (capped at the table length), then the output register.
//  - Sine and cosine run in three free-running CORDIC cell rows fed from the
//    angle registers; they settle after reset and after every register write,
//    and s_tready stays low until the settle counter has run down.
//  - Stall: the whole pipeline holds while the output register is full and
//    m_tready is low; s_tready drops with it. When the result is taken the
//    pipeline moves and a new beat is taken in the same cycle.
`default_nettype none
`include "galvo_point_to_angles_assert.svh"
module galvo_point_to_angles #(
    parameter int CORDIC_STEPS = gpa_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // optical_x[15:0], optical_y[31:16]
    output logic [0:0]  m_tuser,   // angles_valid[0]
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N      = (CORDIC_STEPS > gpa_pkg::TAB_LEN) ? gpa_pkg::TAB_LEN
                                                              : CORDIC_STEPS;
    localparam int RW     = gpa_pkg::ROOT_W;
    localparam int LAT    = 9 + RW + N;
    localparam int SET_W  = $clog2(N + 3);
    localparam logic [SET_W-1:0] SETTLE = SET_W'(N + 2);
    localparam int CW     = gpa_pkg::COORD_W;
    localparam int ZW     = gpa_pkg::Z_W;
    localparam int SXY    = gpa_pkg::SC_XY_W;
    localparam int VXY    = gpa_pkg::VEC_XY_W;
    localparam int IW     = gpa_pkg::IN_W;
    localparam logic signed [17:0] A180 = 18'(gpa_pkg::DEG180);
    localparam logic signed [17:0] A90  = 18'(gpa_pkg::DEG90);
    localparam logic signed [gpa_pkg::OUT_W-1:0] OMAX = gpa_pkg::OUT_W'(gpa_pkg::OUT_MAX);

    // ---------------- config registers ----------------
    logic signed [IW-1:0]                 offset_x_reg, offset_y_reg, offset_z_reg;
    logic signed [gpa_pkg::ANG_W-1:0]     angle_x_reg, angle_y_reg, angle_z_reg;
    logic [gpa_pkg::GAP_W-1:0]            mirror_gap_reg;
    logic [SET_W-1:0]                     settle_reg;
    logic                                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
            angle_x_reg    <= '0;
            angle_y_reg    <= '0;
            angle_z_reg    <= '0;
            mirror_gap_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                gpa_pkg::REG_OFFSET_X:   offset_x_reg   <= pwdata[IW-1:0];
                gpa_pkg::REG_OFFSET_Y:   offset_y_reg   <= pwdata[IW-1:0];
                gpa_pkg::REG_OFFSET_Z:   offset_z_reg   <= pwdata[IW-1:0];
                gpa_pkg::REG_ANGLE_X:    angle_x_reg    <= pwdata[gpa_pkg::ANG_W-1:0];
                gpa_pkg::REG_ANGLE_Y:    angle_y_reg    <= pwdata[gpa_pkg::ANG_W-1:0];
                gpa_pkg::REG_ANGLE_Z:    angle_z_reg    <= pwdata[gpa_pkg::ANG_W-1:0];
                gpa_pkg::REG_MIRROR_GAP: mirror_gap_reg <= pwdata[gpa_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            gpa_pkg::REG_OFFSET_X:   prdata = 32'(offset_x_reg[IW-1:0]);
            gpa_pkg::REG_OFFSET_Y:   prdata = 32'(offset_y_reg[IW-1:0]);
            gpa_pkg::REG_OFFSET_Z:   prdata = 32'(offset_z_reg[IW-1:0]);
            gpa_pkg::REG_ANGLE_X:    prdata = 32'(angle_x_reg[gpa_pkg::ANG_W-1:0]);
            gpa_pkg::REG_ANGLE_Y:    prdata = 32'(angle_y_reg[gpa_pkg::ANG_W-1:0]);
            gpa_pkg::REG_ANGLE_Z:    prdata = 32'(angle_z_reg[gpa_pkg::ANG_W-1:0]);
            gpa_pkg::REG_MIRROR_GAP: prdata = 32'(mirror_gap_reg);
            default:                 prdata = '0;
        endcase
    end

    // sincos rows need to settle after any change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE;
        else if (cfg_wr)
            settle_reg <= SETTLE;
        else if (settle_reg != '0)
            settle_reg <= settle_reg - SET_W'(1);
    end

    // ---------------- sine / cosine rows ----------------
    // index 0: angle_x, 1: angle_y, 2: angle_z
    logic signed [gpa_pkg::ANG_W-1:0] ang_raw [3];
    logic signed [17:0]               a1 [3];
    logic signed [17:0]               a2 [3];
    logic                             fneg [3];
    logic signed [SXY-1:0]            scx [3][N+1];
    logic signed [SXY-1:0]            scy [3][N+1];
    logic signed [ZW-1:0]             scz [3][N+1];
    logic                             negd_reg [3][N];
    gpa_pkg::coef_t                   cos_reg [3];
    gpa_pkg::coef_t                   sin_reg [3];
    gpa_pkg::coef_t                   nsin_reg [3];

    assign ang_raw[0] = angle_x_reg;
    assign ang_raw[1] = angle_y_reg;
    assign ang_raw[2] = angle_z_reg;

    // wrap to (-180, 180], then fold into [-90, 90] with a sign flip
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (18'(ang_raw[k]) > A180)
                a1[k] = 18'(ang_raw[k]) - (A180 + A180);
            else if (18'(ang_raw[k]) <= -A180)
                a1[k] = 18'(ang_raw[k]) + (A180 + A180);
            else
                a1[k] = 18'(ang_raw[k]);
            if (a1[k] > A90)
            begin
                a2[k]   = a1[k] - A180;
                fneg[k] = 1'b1;
            end
            else if (a1[k] < -A90)
            begin
                a2[k]   = a1[k] + A180;
                fneg[k] = 1'b1;
            end
            else
            begin
                a2[k]   = a1[k];
                fneg[k] = 1'b0;
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_sc
        assign scx[k][0] = SXY'(gpa_pkg::GAIN_Q30);
        assign scy[k][0] = '0;
        assign scz[k][0] = ZW'(a2[k]) <<< 8;

        for (genvar i = 0; i < N; i++)
        begin : g_cell
            gpa_cordic_cell #(
                .XY_W   (SXY),
                .Z_W    (ZW),
                .STEP   (i),
                .VECTOR (1'b0)
            ) u_cell (
                .clk   (clk),
                .en    (1'b1),
                .x_in  (scx[k][i]),
                .y_in  (scy[k][i]),
                .z_in  (scz[k][i]),
                .x_out (scx[k][i+1]),
                .y_out (scy[k][i+1]),
                .z_out (scz[k][i+1])
            );

            always_ff @(posedge clk)
            begin
                negd_reg[k][i] <= (i == 0) ? fneg[k] : negd_reg[k][(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            cos_reg[k]  <= gpa_pkg::COEF_W'(negd_reg[k][N-1] ? -scx[k][N] : scx[k][N]);
            sin_reg[k]  <= gpa_pkg::COEF_W'(negd_reg[k][N-1] ? -scy[k][N] : scy[k][N]);
            nsin_reg[k] <= gpa_pkg::COEF_W'(negd_reg[k][N-1] ? scy[k][N] : -scy[k][N]);
        end
    end

    // ---------------- pipeline control ----------------
    logic             en;
    logic             accept;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   bad_reg;
    logic [LAT-1:0]   bad_next;
    logic             pz_bad;
    logic             z2_bad;
    logic             out_valid_reg;
    logic signed [gpa_pkg::OUT_W-1:0] ox_reg, oy_reg;
    logic             ok_reg;

    // the output register parts the pipeline from the receiver
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && (settle_reg == '0);
    assign accept   = s_tvalid && s_tready;

    logic signed [IW-1:0] px, py, pz;
    assign px     = s_tdata[23:0];
    assign py     = s_tdata[47:24];
    assign pz     = s_tdata[71:48];
    assign pz_bad = (pz <= IW'(0));

    always_comb
    begin
        bad_next    = {bad_reg[LAT-2:0], pz_bad};
        bad_next[5] = bad_reg[4] | z2_bad;   // rotated z checked after second rotation
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], accept};
            bad_reg       <= bad_next;
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // ---------------- offset and rotations ----------------
    gpa_pkg::coord_t dx_reg, dy_reg, dz_reg, dx_d1_reg, dx_d2_reg;
    gpa_pkg::coord_t y1, z1, x2, z2, xg, yg;
    gpa_pkg::coord_t y1_d1_reg, y1_d2_reg, z2_d1_reg, zeff_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= CW'(px) - CW'(offset_x_reg);
            dy_reg    <= CW'(py) - CW'(offset_y_reg);
            dz_reg    <= CW'(pz) - CW'(offset_z_reg);
            dx_d1_reg <= dx_reg;
            dx_d2_reg <= dx_d1_reg;
            y1_d1_reg <= y1;
            y1_d2_reg <= y1_d1_reg;
            z2_d1_reg <= z2;
            zeff_reg  <= z2_d1_reg + CW'(mirror_gap_reg);
        end
    end

    assign z2_bad = (z2 <= CW'(0));

    // y angle on (y, z)
    gpa_mac u_rot_y (
        .clk (clk), .en (en), .a (dy_reg), .b (dz_reg),
        .k1a (cos_reg[1]), .k1b (sin_reg[1]),
        .k2a (nsin_reg[1]), .k2b (cos_reg[1]),
        .o1 (y1), .o2 (z1)
    );

    // x angle on (x, z)
    gpa_mac u_rot_x (
        .clk (clk), .en (en), .a (dx_d2_reg), .b (z1),
        .k1a (cos_reg[0]), .k1b (nsin_reg[0]),
        .k2a (sin_reg[0]), .k2b (cos_reg[0]),
        .o1 (x2), .o2 (z2)
    );

    // z angle on (x, y)
    gpa_mac u_rot_z (
        .clk (clk), .en (en), .a (x2), .b (y1_d2_reg),
        .k1a (cos_reg[2]), .k1b (sin_reg[2]),
        .k2a (nsin_reg[2]), .k2b (cos_reg[2]),
        .o1 (xg), .o2 (yg)
    );

    // ---------------- squares and sum ----------------
    logic signed [2*CW-1:0]      ysq_reg, zsq_reg;
    logic [gpa_pkg::SUM_W-1:0]   sum_reg;
    gpa_pkg::coord_t             xg7_reg, yg7_reg, ze7_reg, xg8_reg, yg8_reg, ze8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ysq_reg <= (2*CW)'(yg) * (2*CW)'(yg);
            zsq_reg <= (2*CW)'(zeff_reg) * (2*CW)'(zeff_reg);
            xg7_reg <= xg;
            yg7_reg <= yg;
            ze7_reg <= zeff_reg;
            sum_reg <= gpa_pkg::SUM_W'($unsigned(ysq_reg))
                     + gpa_pkg::SUM_W'($unsigned(zsq_reg));
            xg8_reg <= xg7_reg;
            yg8_reg <= yg7_reg;
            ze8_reg <= ze7_reg;
        end
    end

    // ---------------- square root row ----------------
    logic [gpa_pkg::SUM_W-1:0] srem [RW+1];
    logic [RW-1:0]             sroot [RW+1];
    gpa_pkg::coord_t           sxg_reg [RW];
    gpa_pkg::coord_t           syg_reg [RW];
    gpa_pkg::coord_t           sze_reg [RW];

    assign srem[0]  = sum_reg;
    assign sroot[0] = '0;

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        gpa_sqrt_cell #(
            .SUM_W  (gpa_pkg::SUM_W),
            .ROOT_W (RW),
            .BIT    (RW - 1 - j)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (srem[j]),
            .root_in  (sroot[j]),
            .rem_out  (srem[j+1]),
            .root_out (sroot[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sxg_reg[j] <= (j == 0) ? xg8_reg : sxg_reg[(j == 0) ? 0 : j - 1];
                syg_reg[j] <= (j == 0) ? yg8_reg : syg_reg[(j == 0) ? 0 : j - 1];
                sze_reg[j] <= (j == 0) ? ze8_reg : sze_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---------------- vectoring rows ----------------
    // row 0: atan2(xg, r); row 1: atan2(yg, zeff)
    logic [RW-1:0]          root_c;
    logic signed [VXY-1:0]  vx [2][N+1];
    logic signed [VXY-1:0]  vy [2][N+1];
    logic signed [ZW-1:0]   vz [2][N+1];

    assign root_c   = (sroot[RW] == '0) ? RW'(1) : sroot[RW];
    assign vx[0][0] = VXY'(root_c) <<< gpa_pkg::VEC_SHIFT;
    assign vy[0][0] = VXY'(sxg_reg[RW-1]) <<< gpa_pkg::VEC_SHIFT;
    assign vx[1][0] = VXY'(sze_reg[RW-1]) <<< gpa_pkg::VEC_SHIFT;
    assign vy[1][0] = VXY'(syg_reg[RW-1]) <<< gpa_pkg::VEC_SHIFT;
    assign vz[0][0] = '0;
    assign vz[1][0] = '0;

    for (genvar k = 0; k < 2; k++)
    begin : g_vec
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            gpa_cordic_cell #(
                .XY_W   (VXY),
                .Z_W    (ZW),
                .STEP   (i),
                .VECTOR (1'b1)
            ) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (vx[k][i]),
                .y_in  (vy[k][i]),
                .z_in  (vz[k][i]),
                .x_out (vx[k][i+1]),
                .y_out (vy[k][i+1]),
                .z_out (vz[k][i+1])
            );
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg <= !bad_reg[LAT-1];
            ox_reg <= bad_reg[LAT-1] ? '0 : gpa_pkg::round_sat(vz[0][N]);
            oy_reg <= bad_reg[LAT-1] ? '0 : gpa_pkg::round_sat(vz[1][N]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tuser  = ok_reg;

    // ---------------- checks ----------------
    `GPA_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
    `GPA_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr, !s_tready)
    `GPA_ASSERT_NOW(a_x_in_range, m_tvalid && ok_reg, ox_reg <= OMAX && ox_reg >= -OMAX)

endmodule
`default_nettype wire
